// ===== rtl/core/vrot_pkg.sv =====
// vrot_pkg: shared constants, types and helpers for the vector rotation core
// no dependencies; imported by vrot_cordic, vrot_norm and the top level

package vrot_pkg;

  // pipeline depth of the axis normalizer: 4 front stages, 32 sqrt steps,
  // 31 divider steps and one output register
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int NORM_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;
  // stages behind the normalizer: q product, q scale, cross 1, t, cross 2, out
  localparam int BACK_LAT   = 6;

  localparam logic signed [34:0] Q30_ONE     = 35'sd1073741824;
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

  // unit axis word handed from the normalizer to the rotation datapath
  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic               zero;
  } vrot_unit_t;

  // arctangent of 2^-i in q.30, truncated
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd7;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [67:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

endpackage

// ===== rtl/core/vec3_axis_angle_rotate_top.sv =====
// vec3_axis_angle_rotate_top: rotates a q16.16 vector about an axis by an angle
// instantiates vrot_cordic and vrot_norm; uses vrot_pkg

// Fully pipelined: busy is never raised, a new word may be started in every
// cycle, and each result appears on out_valid after the axis normalizer (32
// square root steps and 31 divider steps, one bit each) and the quaternion
// products; the cordic runs alongside and is delayed to match whatever
// CORDIC_STAGES is. The result is shown for a single cycle and cannot be
// held off, so the receiver must take it when out_valid is high.
// out_axis_zero is set only in mode 1.

module vec3_axis_angle_rotate_top import vrot_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic signed [23:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_axis_zero,
  output logic               out_saturated
);

  localparam int F          = (FRAC_BITS > 30) ? 30 : FRAC_BITS;
  localparam int QSH        = 60 - F;
  localparam int NST        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CORDIC_LAT = NST + 2;
  localparam int CS_DLY     = NORM_LAT - CORDIC_LAT;
  localparam int TOTAL_LAT  = NORM_LAT + BACK_LAT;

  assign busy = 1'b0;

  // front delay lines, aligned with the normalizer
  logic signed [31:0] v_d_r [0:NORM_LAT-1][0:2];
  logic signed [31:0] a_d_r [0:NORM_LAT-1][0:2];
  logic               mode_d_r [0:NORM_LAT-1];
  logic               vld_d_r  [0:NORM_LAT-1];

  always_ff @(posedge clk) begin
    v_d_r[0][0]  <= in_vec_x;
    v_d_r[0][1]  <= in_vec_y;
    v_d_r[0][2]  <= in_vec_z;
    a_d_r[0][0]  <= in_axis_x;
    a_d_r[0][1]  <= in_axis_y;
    a_d_r[0][2]  <= in_axis_z;
    mode_d_r[0]  <= in_mode;
    for (int k = 1; k < NORM_LAT; k++) begin
      v_d_r[k]    <= v_d_r[k-1];
      a_d_r[k]    <= a_d_r[k-1];
      mode_d_r[k] <= mode_d_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NORM_LAT; k++) vld_d_r[k] <= 1'b0;
    end else begin
      vld_d_r[0] <= start && !busy;
      for (int k = 1; k < NORM_LAT; k++) vld_d_r[k] <= vld_d_r[k-1];
    end
  end

  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  vrot_unit_t         unit;

  vrot_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .angle (in_angle),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  vrot_norm u_norm (
    .clk    (clk),
    .axis_x (in_axis_x),
    .axis_y (in_axis_y),
    .axis_z (in_axis_z),
    .unit   (unit)
  );

  logic signed [31:0] w_d_r [0:CS_DLY-1];
  logic signed [31:0] s_d_r [0:CS_DLY-1];

  always_ff @(posedge clk) begin
    w_d_r[0] <= cos_q;
    s_d_r[0] <= sin_q;
    for (int k = 1; k < CS_DLY; k++) begin
      w_d_r[k] <= w_d_r[k-1];
      s_d_r[k] <= s_d_r[k-1];
    end
  end

  logic signed [31:0] v0 [0:2];
  logic signed [31:0] mop [0:2];
  logic               mode0;
  logic               zero0;

  always_comb begin
    mode0  = mode_d_r[NORM_LAT-1];
    zero0  = mode0 && unit.zero;
    v0     = v_d_r[NORM_LAT-1];
    mop[0] = mode0 ? unit.ux : a_d_r[NORM_LAT-1][0];
    mop[1] = mode0 ? unit.uy : a_d_r[NORM_LAT-1][1];
    mop[2] = mode0 ? unit.uz : a_d_r[NORM_LAT-1][2];
  end

  // b1: axis times sine
  logic signed [63:0] p1_r [0:2];
  logic signed [31:0] v1_r [0:2];
  logic signed [31:0] w1_r;
  logic               mode1_r;
  logic               zero1_r;
  logic               vld1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1_r[i] <= 64'(mop[i]) * 64'(s_d_r[CS_DLY-1]);
    end
    v1_r    <= v0;
    w1_r    <= w_d_r[CS_DLY-1];
    mode1_r <= mode0;
    zero1_r <= zero0;
  end

  // b2: scale and clip q
  logic signed [67:0] qs [0:2];
  logic signed [31:0] q2_r [0:2];
  logic signed [31:0] v2_r [0:2];
  logic signed [31:0] w2_r;
  logic               sat2_r;
  logic               zero2_r;
  logic               vld2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = mode1_r ? 68'(p1_r[i] >>> QSH) : 68'(p1_r[i] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q2_r[i] <= sat32(qs[i]);
    sat2_r  <= ovf32(qs[0]) || ovf32(qs[1]) || ovf32(qs[2]);
    v2_r    <= v1_r;
    w2_r    <= w1_r;
    zero2_r <= zero1_r;
  end

  // b3: q x v and w * v products
  logic signed [63:0] qva_r [0:2];
  logic signed [63:0] qvb_r [0:2];
  logic signed [63:0] wv_r  [0:2];
  logic signed [31:0] q3_r [0:2];
  logic signed [31:0] v3_r [0:2];
  logic               sat3_r;
  logic               zero3_r;
  logic               vld3_r;

  always_ff @(posedge clk) begin
    qva_r[0] <= 64'(q2_r[1]) * 64'(v2_r[2]);
    qvb_r[0] <= 64'(q2_r[2]) * 64'(v2_r[1]);
    qva_r[1] <= 64'(q2_r[2]) * 64'(v2_r[0]);
    qvb_r[1] <= 64'(q2_r[0]) * 64'(v2_r[2]);
    qva_r[2] <= 64'(q2_r[0]) * 64'(v2_r[1]);
    qvb_r[2] <= 64'(q2_r[1]) * 64'(v2_r[0]);
    for (int i = 0; i < 3; i++) wv_r[i] <= 64'(w2_r) * 64'(v2_r[i]);
    q3_r    <= q2_r;
    v3_r    <= v2_r;
    sat3_r  <= sat2_r;
    zero3_r <= zero2_r;
  end

  // b4: t = q x v + w v
  logic signed [64:0] c1 [0:2];
  logic signed [67:0] ts [0:2];
  logic signed [31:0] t4_r [0:2];
  logic signed [31:0] q4_r [0:2];
  logic signed [31:0] v4_r [0:2];
  logic               sat4_r;
  logic               zero4_r;
  logic               vld4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1[i] = 65'(qva_r[i]) - 65'(qvb_r[i]);
      ts[i] = 68'(c1[i] >>> F) + 68'(wv_r[i] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) t4_r[i] <= sat32(ts[i]);
    sat4_r  <= sat3_r || ovf32(ts[0]) || ovf32(ts[1]) || ovf32(ts[2]);
    q4_r    <= q3_r;
    v4_r    <= v3_r;
    zero4_r <= zero3_r;
  end

  // b5: q x t products
  logic signed [63:0] qta_r [0:2];
  logic signed [63:0] qtb_r [0:2];
  logic signed [31:0] v5_r [0:2];
  logic               sat5_r;
  logic               zero5_r;
  logic               vld5_r;

  always_ff @(posedge clk) begin
    qta_r[0] <= 64'(q4_r[1]) * 64'(t4_r[2]);
    qtb_r[0] <= 64'(q4_r[2]) * 64'(t4_r[1]);
    qta_r[1] <= 64'(q4_r[2]) * 64'(t4_r[0]);
    qtb_r[1] <= 64'(q4_r[0]) * 64'(t4_r[2]);
    qta_r[2] <= 64'(q4_r[0]) * 64'(t4_r[1]);
    qtb_r[2] <= 64'(q4_r[1]) * 64'(t4_r[0]);
    v5_r    <= v4_r;
    sat5_r  <= sat4_r;
    zero5_r <= zero4_r;
  end

  // b6: out = v + 2 q x t, result register
  logic signed [64:0] c2 [0:2];
  logic signed [31:0] c2s [0:2];
  logic signed [67:0] rs [0:2];
  logic signed [31:0] r6_nxt [0:2];
  logic               sat6_nxt;
  logic signed [31:0] r6_r [0:2];
  logic               sat6_r;
  logic               zero6_r;
  logic               vld6_r;

  always_comb begin
    sat6_nxt = sat5_r;
    for (int i = 0; i < 3; i++) begin
      c2[i]  = 65'(qta_r[i]) - 65'(qtb_r[i]);
      c2s[i] = sat32(68'(c2[i] >>> F));
      rs[i]  = 68'(v5_r[i]) + (68'(c2s[i]) <<< 1);
      if (zero5_r) begin
        r6_nxt[i] = v5_r[i];
      end else begin
        r6_nxt[i] = sat32(rs[i]);
        if (ovf32(rs[i])) sat6_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    r6_r    <= r6_nxt;
    sat6_r  <= sat6_nxt;
    zero6_r <= zero5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld1_r <= vld_d_r[NORM_LAT-1];
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  assign out_valid     = vld6_r;
  assign out_x         = r6_r[0];
  assign out_y         = r6_r[1];
  assign out_z         = r6_r[2];
  assign out_axis_zero = vld6_r && zero6_r;
  assign out_saturated = vld6_r && sat6_r;

  // a result only ever follows a started word by the full latency
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOTAL_LAT))
    else $error("result without a started word");

  // zero axis passes the vector through untouched; x and z are checked
  a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_axis_zero) |->
      (out_x == $past(in_vec_x, TOTAL_LAT)
       && out_z == $past(in_vec_z, TOTAL_LAT)))
    else $error("zero axis result differs from vector");

  // zero axis can only come from a mode 1 word
  a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_axis_zero) |-> $past(in_mode, TOTAL_LAT))
    else $error("zero axis flagged in mode 0");

endmodule

// ===== rtl/core/vrot_cordic.sv =====
// vrot_cordic: pipelined cordic giving cos and sin of half the input angle
// one register per rotation step; uses vrot_pkg for the arctangent table

module vrot_cordic import vrot_pkg::*; #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic signed [23:0] angle,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic signed [34:0] x_r [0:NST];
  logic signed [34:0] y_r [0:NST];
  logic signed [34:0] z_r [0:NST];
  logic               neg_r [0:NST];

  logic signed [34:0] z0;
  logic signed [34:0] cx;
  logic signed [34:0] cy;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  // half angle in q.30 folded into [-pi/2, pi/2]
  assign z0 = 35'(angle) <<< 9;

  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    if (z0 > Q30_HALF_PI) begin
      z_r[0]   <= z0 - Q30_PI;
      neg_r[0] <= 1'b1;
    end else if (z0 < -Q30_HALF_PI) begin
      z_r[0]   <= z0 + Q30_PI;
      neg_r[0] <= 1'b1;
    end else begin
      z_r[0]   <= z0;
      neg_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_step
    logic signed [34:0] at;
    assign at = 35'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - at;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + at;
      end
    end
  end

  always_comb begin
    cx = x_r[NST];
    cy = y_r[NST];
    if (cx > Q30_ONE) cx = Q30_ONE;
    if (cx < -Q30_ONE) cx = -Q30_ONE;
    if (cy > Q30_ONE) cy = Q30_ONE;
    if (cy < -Q30_ONE) cy = -Q30_ONE;
    if (neg_r[NST]) begin
      cx = -cx;
      cy = -cy;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cx[31:0];
    sin_r <= cy[31:0];
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

// ===== rtl/core/vrot_norm.sv =====
// vrot_norm: axis normalizer, scale up, sum of squares, bit-per-stage
// square root and bit-per-stage divider; uses vrot_pkg for vrot_unit_t

module vrot_norm import vrot_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  output vrot_unit_t         unit
);

  logic [31:0] ain [0:2];
  assign ain[0] = axis_x;
  assign ain[1] = axis_y;
  assign ain[2] = axis_z;

  // stage a: magnitudes and largest one
  logic [31:0] mag_a_r [0:2];
  logic        neg_a_r [0:2];
  logic [31:0] m_a_r;
  logic [31:0] mag_nxt [0:2];
  logic [31:0] m_nxt;

  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = ain[i][31] ? (32'd0 - ain[i]) : ain[i];
      if (mag_nxt[i] > m_nxt) m_nxt = mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    m_a_r <= m_nxt;
    for (int i = 0; i < 3; i++) begin
      mag_a_r[i] <= mag_nxt[i];
      neg_a_r[i] <= ain[i][31];
    end
  end

  // stage b: shift all up until the largest reaches 2^30
  logic [4:0]  msb;
  logic [4:0]  sh;
  logic [31:0] smag_b_r [0:2];
  logic        neg_b_r [0:2];
  logic        zero_b_r;

  always_comb begin
    msb = '0;
    for (int k = 0; k < 31; k++) begin
      if (m_a_r[k]) msb = 5'(k);
    end
    sh = (m_a_r[31] || m_a_r[30]) ? 5'd0 : (5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    zero_b_r <= (m_a_r == '0);
    for (int i = 0; i < 3; i++) begin
      smag_b_r[i] <= mag_a_r[i] << sh;
      neg_b_r[i]  <= neg_a_r[i];
    end
  end

  // stage c: squares
  logic [63:0] sq_c_r [0:2];
  logic [31:0] smag_c_r [0:2];
  logic        neg_c_r [0:2];
  logic        zero_c_r;

  always_ff @(posedge clk) begin
    zero_c_r <= zero_b_r;
    for (int i = 0; i < 3; i++) begin
      sq_c_r[i]   <= 64'(smag_b_r[i]) * 64'(smag_b_r[i]);
      smag_c_r[i] <= smag_b_r[i];
      neg_c_r[i]  <= neg_b_r[i];
    end
  end

  // stage d and square root steps; index 0 holds the sum
  logic [63:0] n_s_r   [0:SQRT_STEPS];
  logic [63:0] res_s_r [0:SQRT_STEPS];
  logic [31:0] smag_s_r [0:SQRT_STEPS][0:2];
  logic        neg_s_r  [0:SQRT_STEPS][0:2];
  logic        zero_s_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    n_s_r[0]    <= sq_c_r[0] + sq_c_r[1] + sq_c_r[2];
    res_s_r[0]  <= '0;
    zero_s_r[0] <= zero_c_r;
    for (int i = 0; i < 3; i++) begin
      smag_s_r[0][i] <= smag_c_r[i];
      neg_s_r[0][i]  <= neg_c_r[i];
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = res_s_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (n_s_r[j] >= trial) begin
        n_s_r[j+1]   <= n_s_r[j] - trial;
        res_s_r[j+1] <= (res_s_r[j] >> 1) + BIT;
      end else begin
        n_s_r[j+1]   <= n_s_r[j];
        res_s_r[j+1] <= res_s_r[j] >> 1;
      end
      zero_s_r[j+1] <= zero_s_r[j];
      for (int i = 0; i < 3; i++) begin
        smag_s_r[j+1][i] <= smag_s_r[j][i];
        neg_s_r[j+1][i]  <= neg_s_r[j][i];
      end
    end
  end

  // divider: (smag << 30) / len; the quotient fits 31 bits since smag <= len,
  // so the remainder starts at smag >> 1 and only smag[0] is still to come
  logic [33:0] rem_r  [0:DIV_STEPS][0:2];
  logic [30:0] quo_r  [0:DIV_STEPS][0:2];
  logic        lsb_r  [0:DIV_STEPS][0:2];
  logic        neg_d_r [0:DIV_STEPS][0:2];
  logic [32:0] den_r  [0:DIV_STEPS];
  logic        zero_d_r [0:DIV_STEPS];

  always_comb begin
    den_r[0]    = res_s_r[SQRT_STEPS][32:0];
    zero_d_r[0] = zero_s_r[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i]   = 34'(smag_s_r[SQRT_STEPS][i] >> 1);
      quo_r[0][i]   = '0;
      lsb_r[0][i]   = smag_s_r[SQRT_STEPS][i][0];
      neg_d_r[0][i] = neg_s_r[SQRT_STEPS][i];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [33:0] r2 [0:2];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {rem_r[j][i][32:0], lsb_r[j][i]};
      end
    end
    always_ff @(posedge clk) begin
      den_r[j+1]    <= den_r[j];
      zero_d_r[j+1] <= zero_d_r[j];
      for (int i = 0; i < 3; i++) begin
        lsb_r[j+1][i]   <= 1'b0;
        neg_d_r[j+1][i] <= neg_d_r[j][i];
        if (r2[i] >= 34'(den_r[j])) begin
          rem_r[j+1][i] <= r2[i] - 34'(den_r[j]);
          quo_r[j+1][i] <= {quo_r[j][i][29:0], 1'b1};
        end else begin
          rem_r[j+1][i] <= r2[i];
          quo_r[j+1][i] <= {quo_r[j][i][29:0], 1'b0};
        end
      end
    end
  end

  logic signed [31:0] u_r [0:2];
  logic               zero_r;

  always_ff @(posedge clk) begin
    zero_r <= zero_d_r[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      if (zero_d_r[DIV_STEPS]) begin
        u_r[i] <= '0;
      end else if (neg_d_r[DIV_STEPS][i]) begin
        u_r[i] <= 32'sd0 - 32'(quo_r[DIV_STEPS][i]);
      end else begin
        u_r[i] <= 32'(quo_r[DIV_STEPS][i]);
      end
    end
  end

  assign unit.ux   = u_r[0];
  assign unit.uy   = u_r[1];
  assign unit.uz   = u_r[2];
  assign unit.zero = zero_r;

endmodule

// ===== test/vec3_axis_angle_rotate_top_tb.sv =====
// vec3_axis_angle_rotate_top_tb: self-checking bench for the axis-angle vector rotator
// depends on vrot_pkg and vec3_axis_angle_rotate_top; predicts every word in place
`timescale 1ns / 1ps

module vec3_axis_angle_rotate_top_tb import vrot_pkg::*;;

  localparam int FRAC = 16;
  localparam int STAGES = 20;
  localparam int LATENCY = NORM_LAT + BACK_LAT;

  typedef struct {
    logic               mode;
    logic signed [31:0] vec [3];
    logic signed [31:0] axis [3];
    logic signed [23:0] angle;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic               zero;
    logic               sat;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [31:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic signed [23:0] in_angle = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_axis_zero, out_saturated;

  rot_req_t pending_q[$];
  rot_res_t expected_q[$];
  int mismatches = 0;
  bit feed_done = 0;
  bit hold_feed = 0;
  bit quiet_gaps = 0;

  always #4 clk = ~clk;

  vec3_axis_angle_rotate_top #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_angle(in_angle), .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_axis_zero(out_axis_zero), .out_saturated(out_saturated)
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl [32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1, 0, 0};
    return tbl[i];
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t rq);
    rot_res_t res;
    longint z, x, y, nx, w, s, m, u;
    longint v[3], a[3], q[3], t[3], c1[3], c2[3], c;
    longint unsigned mag[3], mx, sum, len;
    bit sat, zero, neg, dummy;
    int sh;
    sat = 0; zero = 0; neg = 0; dummy = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = rq.vec[i];
      a[i] = rq.axis[i];
    end
    z = longint'(rq.angle) * 512;
    x = 652032874;
    y = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= arctan_step(i);
      end else begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += arctan_step(i);
      end
      x = nx;
    end
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    if (y < -64'sd1073741824) y = -64'sd1073741824;
    w = neg ? -x : x;
    s = neg ? -y : y;
    if (!rq.mode) begin
      for (int i = 0; i < 3; i++) q[i] = clip32(floor_shift(a[i] * s, 30), sat);
    end else begin
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = a[i] < 0 ? -a[i] : a[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        zero = 1;
        for (int i = 0; i < 3; i++) q[i] = 0;
      end else begin
        sh = 0;
        while ((mx << sh) < (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
          mag[i] <<= sh;
          sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
          u = longint'((mag[i] << 30) / len);
          if (a[i] < 0) u = -u;
          q[i] = clip32(floor_shift(u * s, 60 - FRAC), sat);
        end
      end
    end
    c1[0] = q[1] * v[2] - q[2] * v[1];
    c1[1] = q[2] * v[0] - q[0] * v[2];
    c1[2] = q[0] * v[1] - q[1] * v[0];
    for (int i = 0; i < 3; i++)
      t[i] = clip32(floor_shift(c1[i], FRAC) + floor_shift(w * v[i], 30), sat);
    c2[0] = q[1] * t[2] - q[2] * t[1];
    c2[1] = q[2] * t[0] - q[0] * t[2];
    c2[2] = q[0] * t[1] - q[1] * t[0];
    for (int i = 0; i < 3; i++) begin
      c = clip32(floor_shift(c2[i], FRAC), dummy);
      m = zero ? v[i] : clip32(v[i] + 2 * c, sat);
      res.r[i] = m[31:0];
    end
    res.zero = zero;
    res.sat = sat;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 65535)) - 32768;
      2: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  function automatic rot_req_t make_req(logic m, logic signed [31:0] vx, logic signed [31:0] vy,
      logic signed [31:0] vz, logic signed [31:0] ax, logic signed [31:0] ay,
      logic signed [31:0] az, logic signed [23:0] ang);
    rot_req_t rq;
    rq.mode = m;
    rq.vec[0] = vx; rq.vec[1] = vy; rq.vec[2] = vz;
    rq.axis[0] = ax; rq.axis[1] = ay; rq.axis[2] = az;
    rq.angle = ang;
    return rq;
  endfunction

  // driver: one word per accepted start, the head of the queue is on the ports whenever start is high
  always @(posedge clk) begin
    rot_req_t rq;
    if (rst_n && start && !busy) expected_q.push_back(rotate_vector(pending_q.pop_front()));
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // word still waiting, keep it on the ports
    end else if (hold_feed || pending_q.size() == 0
        || (!quiet_gaps && $urandom_range(0, 99) < 21)) begin
      start <= 1'b0;
    end else begin
      rq = pending_q[0];
      start <= 1'b1;
      in_mode <= rq.mode;
      in_vec_x <= rq.vec[0]; in_vec_y <= rq.vec[1]; in_vec_z <= rq.vec[2];
      in_axis_x <= rq.axis[0]; in_axis_y <= rq.axis[1]; in_axis_z <= rq.axis[2];
      in_angle <= rq.angle;
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word x=%0d y=%0d z=%0d", out_x, out_y, out_z);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.r[0] || out_y !== e.r[1] || out_z !== e.r[2]
            || out_axis_zero !== e.zero || out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d z%0b s%0b got %0d %0d %0d z%0b s%0b",
              e.r[0], e.r[1], e.r[2], e.zero, e.sat,
              out_x, out_y, out_z, out_axis_zero, out_saturated);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [23:0] ang;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: zero axes, extremes, angle limits, non-unit axes
    pending_q.push_back(make_req(1, 65536, -65536, 3, 0, 0, 0, 24'sd1647099));
    pending_q.push_back(make_req(0, 65536, 2, 3, 0, 0, 0, 24'sd1647099));
    pending_q.push_back(make_req(0, 65536, 0, 0, 0, 0, 65536, 24'sd1647099));
    pending_q.push_back(make_req(1, 65536, 0, 0, 0, 0, 5, 24'sd1647099));
    pending_q.push_back(make_req(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
      32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 24'sh7fffff));
    pending_q.push_back(make_req(1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
      32'sh80000000, 32'sh80000000, 32'sh80000000, 24'sh800000));
    pending_q.push_back(make_req(1, 32'sh7fffffff, 1, -1, 32'sh7fffffff, 0, 0, 24'sh400000));
    pending_q.push_back(make_req(0, 100000, -5, 7, 0, 65536, 0, 24'sh000000));
    pending_q.push_back(make_req(1, 100000, -5, 7, 3, -4, 12, -24'sd3294199));
    pending_q.push_back(make_req(0, 100000, 100, 7, 200000, 300000, -100000, 24'sd3294199));
    pending_q.push_back(make_req(1, -1, -1, -1, -1, -1, -1, -24'sd1));
    pending_q.push_back(make_req(0, 32'sh40000000, 32'sh40000000, 0, 0, 0, 32'sh7fffffff, 24'sd1));
    for (int n = 0; n < 1100; n++) begin
      ang = $urandom_range(0, 3) == 0 ? 24'($urandom) :
        $signed(24'($urandom_range(0, 6588397))) - 24'sd3294199;
      pending_q.push_back(make_req($urandom_range(0, 1), rand_comp(), rand_comp(), rand_comp(),
        $urandom_range(0, 15) == 0 ? 32'sd0 : rand_comp(),
        $urandom_range(0, 15) == 0 ? 32'sd0 : rand_comp(),
        $urandom_range(0, 15) == 0 ? 32'sd0 : rand_comp(), ang));
      if (n == 300) begin
        // let the pipe drain once, then run a stretch with no gaps
        wait (pending_q.size() <= 1);
        hold_feed = 1;
        wait (pending_q.size() == 0 || (expected_q.size() == 0 && !start));
        @(posedge clk);
        wait (expected_q.size() == 0);
        hold_feed = 0;
        quiet_gaps = 1;
      end
      if (n == 700) begin
        // keep the gap-free stretch going until most of it has been sent
        wait (pending_q.size() <= 100);
        quiet_gaps = 0;
      end
    end
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
